// ===== rtl/swarq_pkg.sv =====
// ----------------------------------------------------------------------------
// swarq_pkg
// Shared types and constants of the stop-and-wait ARQ engine.
// ----------------------------------------------------------------------------
package swarq_pkg;

    localparam int PEERS        = 16;
    localparam int MAIL_BYTES   = 44;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_PAYLOAD  = MAIL_BYTES - HEADER_BYTES;
    localparam int PEER_W       = (PEERS > 1) ? $clog2(PEERS) : 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT_TICKS = 1'd0,
        CFG_MAX_RETRANS   = 1'd1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_RECV = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_ACK  = 2'd1
    } kind_t;

    typedef enum logic [2:0] {
        EV_SEND_DATA = 3'd0,
        EV_SEND_ACK  = 3'd1,
        EV_DELIVER   = 3'd2,
        EV_SEND_OK   = 3'd3,
        EV_SEND_FAIL = 3'd4,
        EV_SEND_REJ  = 3'd5
    } event_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [7:0]        peer;
        logic [7:0]        payload_len;
        logic [1:0]        packet_kind;
        logic [15:0]       packet_seq;
        logic [15:0]       packet_ack;
        logic signed [7:0] header_len;
        logic [7:0]        message_len;
    } in_item_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  out_peer;
        logic [15:0] out_seq;
        logic [7:0]  out_len;
        logic        last;
    } result_t;

    typedef struct packed {
        logic              vld;
        logic [PEER_W-1:0] idx;
        logic [15:0]       data;
    } fwd_t;

endpackage

// ===== rtl/swarq_in_if.sv =====
// ----------------------------------------------------------------------------
// swarq_in_if
// Input channel: send requests, received headers and ticks.
// ----------------------------------------------------------------------------
interface swarq_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [7:0]        peer;
    logic [7:0]        payload_len;
    logic [1:0]        packet_kind;
    logic [15:0]       packet_seq;
    logic [15:0]       packet_ack;
    logic signed [7:0] header_len;
    logic [7:0]        message_len;

    modport source (
        output valid, operation, peer, payload_len, packet_kind,
               packet_seq, packet_ack, header_len, message_len,
        input  ready
    );

    modport sink (
        input  valid, operation, peer, payload_len, packet_kind,
               packet_seq, packet_ack, header_len, message_len,
        output ready
    );
endinterface

// ===== rtl/swarq_out_if.sv =====
// ----------------------------------------------------------------------------
// swarq_out_if
// Result channel: one event per transaction.
// ----------------------------------------------------------------------------
interface swarq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  out_peer;
    logic [15:0] out_seq;
    logic [7:0]  out_len;
    logic        last;

    modport source (
        output valid, event_res, out_peer, out_seq, out_len, last,
        input  ready
    );

    modport sink (
        input  valid, event_res, out_peer, out_seq, out_len, last,
        output ready
    );
endinterface

// ===== rtl/stop_and_wait_arq_engine.sv =====
// ----------------------------------------------------------------------------
// stop_and_wait_arq_engine
// Header-level stop-and-wait ARQ: per-peer sequence tables in memory, one
// outstanding transmission with retry count and timeout countdown.
//
//   channel   dir   transaction
//   in_ch     in    send request / received header / tick
//   out_ch    out   one event (up to two per input, last marks the final)
//   cfg_*     in    register write, index 0 timeout_ticks, 1 max_retrans
//
// One input per cycle unless stalled; the s1 stage writes results to the FIFO.
// Sequence tables are read at accept, updated in the next cycle; a same-peer
// update on the following item is forwarded.
// Reset clears table valid bits at once; no clearing pass.
// Results queue in an 8-entry FIFO; input stalls when it may not fit two more.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    swarq_in_if.sink                        in_ch,
    swarq_out_if.source                     out_ch,
    input  logic                            cfg_we,
    input  logic [swarq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swarq_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int PW = swarq_pkg::PEER_W;

    // configuration
    logic [15:0] timeout_reg;
    logic [7:0]  max_retrans_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= 16'd100;
            max_retrans_reg <= 8'd3;
        end
        else if (cfg_we)
        begin
            unique case (swarq_pkg::cfg_idx_t'(cfg_index))
                swarq_pkg::CFG_TIMEOUT_TICKS: timeout_reg     <= cfg_data[15:0];
                swarq_pkg::CFG_MAX_RETRANS:   max_retrans_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input capture
    logic                 in_fire;
    logic [PW-1:0]        in_idx;
    swarq_pkg::in_item_t  s1_item_reg;
    logic                 s1_valid_reg;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_idx  = in_ch.peer[PW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_fire;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.operation   <= in_ch.operation;
            s1_item_reg.peer        <= in_ch.peer;
            s1_item_reg.payload_len <= in_ch.payload_len;
            s1_item_reg.packet_kind <= in_ch.packet_kind;
            s1_item_reg.packet_seq  <= in_ch.packet_seq;
            s1_item_reg.packet_ack  <= in_ch.packet_ack;
            s1_item_reg.header_len  <= in_ch.header_len;
            s1_item_reg.message_len <= in_ch.message_len;
        end
    end

    // sequence tables
    logic [15:0]      send_mem [swarq_pkg::PEERS];
    logic [15:0]      recv_mem [swarq_pkg::PEERS];
    logic [swarq_pkg::PEERS-1:0] send_vld_reg;
    logic [swarq_pkg::PEERS-1:0] recv_vld_reg;
    logic [15:0]      send_rd_reg;
    logic [15:0]      recv_rd_reg;
    logic             send_rd_vld_reg;
    logic             recv_rd_vld_reg;
    swarq_pkg::fwd_t  send_fwd_reg;
    swarq_pkg::fwd_t  recv_fwd_reg;

    logic             send_we;
    logic             recv_we;
    logic [PW-1:0]    s1_idx;
    logic [15:0]      send_cur;
    logic [15:0]      recv_cur;

    assign s1_idx = s1_item_reg.peer[PW-1:0];

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            send_rd_reg <= send_mem[in_idx];
            recv_rd_reg <= recv_mem[in_idx];
        end
        if (send_we)
            send_mem[s1_idx] <= send_cur + 16'd1;
        if (recv_we)
            recv_mem[s1_idx] <= recv_cur + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_vld_reg    <= '0;
            recv_vld_reg    <= '0;
            send_rd_vld_reg <= 1'b0;
            recv_rd_vld_reg <= 1'b0;
            send_fwd_reg    <= '0;
            recv_fwd_reg    <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                send_rd_vld_reg <= send_vld_reg[in_idx];
                recv_rd_vld_reg <= recv_vld_reg[in_idx];
            end
            if (send_we)
                send_vld_reg[s1_idx] <= 1'b1;
            if (recv_we)
                recv_vld_reg[s1_idx] <= 1'b1;
            send_fwd_reg.vld  <= send_we;
            send_fwd_reg.idx  <= s1_idx;
            send_fwd_reg.data <= send_cur + 16'd1;
            recv_fwd_reg.vld  <= recv_we;
            recv_fwd_reg.idx  <= s1_idx;
            recv_fwd_reg.data <= recv_cur + 16'd1;
        end
    end

    always_comb
    begin
        if (send_fwd_reg.vld && send_fwd_reg.idx == s1_idx)
            send_cur = send_fwd_reg.data;
        else if (send_rd_vld_reg)
            send_cur = send_rd_reg;
        else
            send_cur = '0;
        if (recv_fwd_reg.vld && recv_fwd_reg.idx == s1_idx)
            recv_cur = recv_fwd_reg.data;
        else if (recv_rd_vld_reg)
            recv_cur = recv_rd_reg;
        else
            recv_cur = '0;
    end

    // outstanding transmission
    logic          awaiting_reg,  awaiting_next;
    logic [PW-1:0] pend_peer_reg, pend_peer_next;
    logic [15:0]   pend_seq_reg,  pend_seq_next;
    logic [7:0]    pend_len_reg,  pend_len_next;
    logic [7:0]    retries_reg,   retries_next;
    logic [15:0]   ticks_reg,     ticks_next;

    logic          peer_ok;
    logic          hdr_ok;
    logic [15:0]   timeout_val;
    logic [15:0]   ticks_dec;
    logic [1:0]    push_n;
    swarq_pkg::result_t res0;
    swarq_pkg::result_t res1;

    assign peer_ok     = {1'b0, s1_item_reg.peer} < 9'(swarq_pkg::PEERS);
    assign timeout_val = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    assign ticks_dec   = (ticks_reg != 16'd0) ? ticks_reg - 16'd1 : 16'd0;

    always_comb
    begin
        hdr_ok = 1'b1;
        if (s1_item_reg.message_len < 8'(swarq_pkg::HEADER_BYTES) ||
            s1_item_reg.message_len > 8'(swarq_pkg::MAIL_BYTES))
            hdr_ok = 1'b0;
        if (s1_item_reg.packet_kind != swarq_pkg::KIND_DATA &&
            s1_item_reg.packet_kind != swarq_pkg::KIND_ACK)
            hdr_ok = 1'b0;
        if (s1_item_reg.header_len[7])
            hdr_ok = 1'b0;
        if (s1_item_reg.packet_kind == swarq_pkg::KIND_ACK &&
            s1_item_reg.header_len != 8'sd0)
            hdr_ok = 1'b0;
        if (9'(swarq_pkg::HEADER_BYTES) + {1'b0, s1_item_reg.header_len[7:0]} !=
            {1'b0, s1_item_reg.message_len})
            hdr_ok = 1'b0;
        if (!peer_ok)
            hdr_ok = 1'b0;
    end

    always_comb
    begin
        awaiting_next  = awaiting_reg;
        pend_peer_next = pend_peer_reg;
        pend_seq_next  = pend_seq_reg;
        pend_len_next  = pend_len_reg;
        retries_next   = retries_reg;
        ticks_next     = ticks_reg;
        send_we        = 1'b0;
        recv_we        = 1'b0;
        push_n         = 2'd0;
        res0           = '{swarq_pkg::EV_SEND_DATA, s1_item_reg.peer, 16'd0,
                           8'd0, 1'b1};
        res1           = '{swarq_pkg::EV_DELIVER, s1_item_reg.peer,
                           s1_item_reg.packet_seq, s1_item_reg.header_len[7:0], 1'b1};
        if (s1_valid_reg)
        begin
            case (swarq_pkg::op_t'(s1_item_reg.operation))
                swarq_pkg::OP_SEND:
                begin
                    push_n       = 2'd1;
                    res0.out_len = s1_item_reg.payload_len;
                    if (!peer_ok || awaiting_reg ||
                        s1_item_reg.payload_len > 8'(swarq_pkg::MAX_PAYLOAD))
                    begin
                        res0.event_res = swarq_pkg::EV_SEND_REJ;
                    end
                    else
                    begin
                        send_we        = 1'b1;
                        awaiting_next  = 1'b1;
                        pend_peer_next = s1_idx;
                        pend_seq_next  = send_cur;
                        pend_len_next  = s1_item_reg.payload_len;
                        retries_next   = 8'd0;
                        ticks_next     = timeout_val;
                        res0.out_seq   = send_cur;
                    end
                end
                swarq_pkg::OP_RECV:
                begin
                    if (hdr_ok && s1_item_reg.packet_kind == swarq_pkg::KIND_ACK)
                    begin
                        if (awaiting_reg && s1_idx == pend_peer_reg &&
                            s1_item_reg.packet_ack == pend_seq_reg)
                        begin
                            awaiting_next  = 1'b0;
                            ticks_next     = 16'd0;
                            push_n         = 2'd1;
                            res0.event_res = swarq_pkg::EV_SEND_OK;
                            res0.out_seq   = pend_seq_reg;
                            res0.out_len   = pend_len_reg;
                        end
                    end
                    else if (hdr_ok)
                    begin
                        res0.event_res = swarq_pkg::EV_SEND_ACK;
                        res0.out_seq   = s1_item_reg.packet_seq;
                        if (s1_item_reg.packet_seq == recv_cur)
                        begin
                            recv_we   = 1'b1;
                            push_n    = 2'd2;
                            res0.last = 1'b0;
                        end
                        else
                        begin
                            push_n = 2'd1;
                        end
                    end
                end
                swarq_pkg::OP_TICK:
                begin
                    if (awaiting_reg)
                    begin
                        ticks_next = ticks_dec;
                        if (ticks_dec == 16'd0)
                        begin
                            push_n        = 2'd1;
                            res0.out_peer = 8'(pend_peer_reg);
                            res0.out_seq  = pend_seq_reg;
                            res0.out_len  = pend_len_reg;
                            if (retries_reg < max_retrans_reg)
                            begin
                                retries_next   = retries_reg + 8'd1;
                                ticks_next     = timeout_val;
                                res0.event_res = swarq_pkg::EV_SEND_DATA;
                            end
                            else
                            begin
                                awaiting_next  = 1'b0;
                                res0.event_res = swarq_pkg::EV_SEND_FAIL;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b0;
            pend_peer_reg <= '0;
            pend_seq_reg  <= '0;
            pend_len_reg  <= '0;
            retries_reg   <= '0;
            ticks_reg     <= '0;
        end
        else
        begin
            awaiting_reg  <= awaiting_next;
            pend_peer_reg <= pend_peer_next;
            pend_seq_reg  <= pend_seq_next;
            pend_len_reg  <= pend_len_next;
            retries_reg   <= retries_next;
            ticks_reg     <= ticks_next;
        end
    end

    // result FIFO
    swarq_pkg::result_t fifo_mem [swarq_pkg::FIFO_DEPTH];
    logic [swarq_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [swarq_pkg::FIFO_CNT_W-1:0] count_reg;
    logic [swarq_pkg::FIFO_PTR_W-1:0] wr_ptr_p1;
    logic                             pop;
    logic [swarq_pkg::FIFO_CNT_W:0]   need;
    swarq_pkg::result_t               head;

    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign pop       = out_ch.valid && out_ch.ready;
    assign need      = {1'b0, count_reg} +
                       (s1_valid_reg ? (swarq_pkg::FIFO_CNT_W+1)'(2) : '0);
    assign in_ch.ready = need <= (swarq_pkg::FIFO_CNT_W+1)'(swarq_pkg::FIFO_DEPTH - 2);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_mem[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            fifo_mem[wr_ptr_p1] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + swarq_pkg::FIFO_PTR_W'(push_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + swarq_pkg::FIFO_CNT_W'(push_n) -
                         swarq_pkg::FIFO_CNT_W'(pop);
        end
    end

    assign head             = fifo_mem[rd_ptr_reg];
    assign out_ch.valid     = count_reg != '0;
    assign out_ch.event_res = head.event_res;
    assign out_ch.out_peer  = head.out_peer;
    assign out_ch.out_seq   = head.out_seq;
    assign out_ch.out_len   = head.out_len;
    assign out_ch.last      = head.last;

    // checks
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= swarq_pkg::FIFO_CNT_W'(swarq_pkg::FIFO_DEPTH))
        else $error("result FIFO overflow");

    a_idle_no_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        !awaiting_reg |-> ticks_reg == 16'd0)
        else $error("countdown running with nothing outstanding");

    a_rise_on_send: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(awaiting_reg) |-> $past(s1_valid_reg &&
            s1_item_reg.operation == swarq_pkg::OP_SEND))
        else $error("outstanding send started without a send request");

    a_accept_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted transaction lost");

    // a retry is only counted while the limit still allowed one
    a_retry_limit: assert property (@(posedge clk) disable iff (!rst_n)
        retries_reg > $past(retries_reg) |-> $past(retries_reg < max_retrans_reg))
        else $error("retry count beyond limit");

endmodule
